// File: hdl/ffba_pkg.sv
`default_nettype none

package ffba_pkg;

   localparam int NUM_BLOCKS  = 64;
   localparam int BLOCK_BYTES = 32;

   localparam int LEN_W      = 16;
   localparam int ADDR_W     = 16;
   localparam int OFF_W      = 11;
   localparam int FREE_W     = 7;
   localparam int BLK_SHIFT  = $clog2(BLOCK_BYTES);
   localparam int IDX_W      = $clog2(NUM_BLOCKS);
   localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
   localparam int NEED_W     = LEN_W + 1 - BLK_SHIFT;
   localparam int HEAP_BYTES = NUM_BLOCKS * BLOCK_BYTES;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

   typedef logic [1:0] mark_type;
   localparam mark_type MARK_FREE = 2'b00;
   localparam mark_type MARK_NEXT = 2'b01;
   localparam mark_type MARK_USED = 2'b10;

   typedef enum logic {
      REQ_ALLOC,
      REQ_FREE
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_NO_SPACE,
      ST_ZERO_LEN,
      ST_IGNORED
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_WRITE,
      S_FREE_CHECK,
      S_FREE_WALK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic       load;
      logic       advance;
      logic       scan;
      logic       wr_alloc;
      logic       wr_free;
      logic       count_add;
      logic       set_status;
      status_type status;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic is_free;
      logic zero_len;
      logic too_big;
      logic addr_bad;
      logic mark_used;
      logic chain_more;
      logic hit;
      logic at_last;
      logic wr_last;
      logic rsp_free;
   } flags_type;

endpackage

`default_nettype wire

// File: hdl/ffba_if.sv
`default_nettype none

interface ffba_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [ffba_pkg::LEN_W-1:0]    length;
   logic [ffba_pkg::ADDR_W-1:0]   address;

   modport source (output valid, req_type, length, address, input ready);
   modport sink   (input valid, req_type, length, address, output ready);
endinterface

interface ffba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic [ffba_pkg::OFF_W-1:0]    offset;
   logic [ffba_pkg::FREE_W-1:0]   free_blocks;
   logic [ffba_pkg::FREE_W-1:0]   lowest_free;

   modport source (output valid, status, offset, free_blocks, lowest_free, input ready);
   modport sink   (input valid, status, offset, free_blocks, lowest_free, output ready);
endinterface

`default_nettype wire

// File: hdl/ffba_ctrl.sv
`default_nettype none

module ffba_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ffba_pkg::flags_type  flags,
   output ffba_pkg::cmd_type    cmd
);
   import ffba_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (flags.is_free) begin
               state_in = flags.addr_bad ? S_DONE : S_FREE_CHECK;
            end else if (flags.zero_len || flags.too_big) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (flags.hit) begin
               state_in = S_WRITE;
            end else if (flags.at_last) begin
               state_in = S_DONE;
            end
         end
         S_WRITE: begin
            if (flags.wr_last) state_in = S_DONE;
         end
         S_FREE_CHECK: begin
            if (!flags.mark_used) begin
               state_in = S_DONE;
            end else if (flags.chain_more) begin
               state_in = S_FREE_WALK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_FREE_WALK: begin
            if (!flags.chain_more) state_in = S_DONE;
         end
         S_DONE: begin
            if (flags.rsp_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      cmd.status = ST_OK;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_DECODE: begin
            if (flags.is_free) begin
               if (flags.addr_bad) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = ST_IGNORED;
               end
            end else if (flags.zero_len) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_ZERO_LEN;
            end else if (flags.too_big) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_NO_SPACE;
            end
         end
         S_SCAN: begin
            cmd.scan    = 1'b1;
            cmd.advance = 1'b1;
            if (flags.hit) begin
               cmd.count_add = 1'b1;
            end else if (flags.at_last) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_NO_SPACE;
            end
         end
         S_WRITE: begin
            cmd.wr_alloc = 1'b1;
            if (flags.wr_last) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_OK;
            end
         end
         S_FREE_CHECK: begin
            if (!flags.mark_used) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_IGNORED;
            end else begin
               cmd.wr_free = 1'b1;
               cmd.advance = flags.chain_more;
               if (!flags.chain_more) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = ST_OK;
               end
            end
         end
         S_FREE_WALK: begin
            cmd.wr_free = 1'b1;
            cmd.advance = flags.chain_more;
            if (!flags.chain_more) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_OK;
            end
         end
         S_DONE: begin
            cmd.rsp_load = flags.rsp_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: hdl/ffba_dp.sv
`default_nettype none

module ffba_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_type,
   input  logic [ffba_pkg::LEN_W-1:0]    req_length,
   input  logic [ffba_pkg::ADDR_W-1:0]   req_address,
   input  ffba_pkg::cmd_type             cmd,
   output ffba_pkg::flags_type           flags,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic [ffba_pkg::OFF_W-1:0]    rsp_offset,
   output logic [ffba_pkg::FREE_W-1:0]   rsp_free_blocks,
   output logic [ffba_pkg::FREE_W-1:0]   rsp_lowest_free
);
   import ffba_pkg::*;

   // block mark memory, valid bit per entry stands for reset
   mark_type                mem [NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0]   valid_ff;
   mark_type                rd_mark_ff;
   logic                    rd_valid_ff;

   logic [IDX_W-1:0]        ptr_ff;
   logic [IDX_W-1:0]        rd_addr;
   logic [IDX_W-1:0]        ptr_next;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   mark_type                wr_data;
   mark_type                mark;

   logic                    is_free_ff;
   logic [NEED_W-1:0]       need_ff;
   logic [NEED_W-1:0]       need_in;
   logic                    addr_bad_ff;
   logic                    addr_bad_in;

   logic [CNT_W-1:0]        run_len_ff;
   logic [CNT_W-1:0]        run_nxt;
   logic [IDX_W-1:0]        run_start_ff;
   logic [IDX_W-1:0]        alloc_start_ff;
   logic                    hit;

   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic [CNT_W-1:0]        peak_ff;
   logic [CNT_W-1:0]        peak_in;
   logic [CNT_W-1:0]        count_sum;

   status_type              status_ff;
   logic                    rsp_valid_ff;
   logic [1:0]              rsp_status_ff;
   logic [OFF_W-1:0]        rsp_offset_ff;
   logic [FREE_W-1:0]       rsp_free_ff;
   logic [FREE_W-1:0]       rsp_lowest_ff;

   // request decode
   assign need_in = NEED_W'(({1'b0, req_length} + (LEN_W + 1)'(BLOCK_BYTES - 1)) >> BLK_SHIFT);
   assign addr_bad_in = ({1'b0, req_address} >= (ADDR_W + 1)'(HEAP_BYTES))
                        || (req_address[BLK_SHIFT-1:0] != '0);

   // read pointer
   assign ptr_next = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + 1'b1;

   always_comb begin
      if (cmd.load) begin
         rd_addr = (req_type == REQ_FREE) ? req_address[BLK_SHIFT +: IDX_W] : '0;
      end else if (cmd.advance) begin
         rd_addr = ptr_next;
      end else begin
         rd_addr = ptr_ff;
      end
   end

   assign wr_en   = cmd.wr_alloc | cmd.wr_free;
   assign wr_addr = cmd.wr_alloc ? run_start_ff : ptr_ff;
   always_comb begin
      if (cmd.wr_free) begin
         wr_data = MARK_FREE;
      end else if (run_len_ff == CNT_W'(1)) begin
         wr_data = MARK_USED;
      end else begin
         wr_data = MARK_USED | MARK_NEXT;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_mark_ff  <= mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
      ptr_ff      <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign mark = rd_valid_ff ? rd_mark_ff : MARK_FREE;

   // first-fit run tracking
   assign run_nxt = run_len_ff + 1'b1;
   assign hit     = (mark == MARK_FREE) && (NEED_W'(run_nxt) == need_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         is_free_ff   <= (req_type == REQ_FREE);
         need_ff      <= need_in;
         addr_bad_ff  <= addr_bad_in;
         run_len_ff   <= '0;
         run_start_ff <= '0;
      end else if (cmd.scan) begin
         if (mark == MARK_FREE) begin
            run_len_ff <= run_nxt;
         end else begin
            run_len_ff   <= '0;
            run_start_ff <= ptr_next;
         end
         if (hit) alloc_start_ff <= run_start_ff;
      end else if (cmd.wr_alloc) begin
         run_len_ff   <= run_len_ff - 1'b1;
         run_start_ff <= run_start_ff + 1'b1;
      end
      if (cmd.set_status) status_ff <= cmd.status;
   end

   // block counts
   assign count_sum = count_ff + CNT_W'(need_ff);

   always_comb begin
      count_in = count_ff;
      peak_in  = peak_ff;
      if (cmd.count_add) begin
         count_in = count_sum;
         if (count_sum > peak_ff) peak_in = count_sum;
      end else if (cmd.wr_free && mark[1] && (count_ff != '0)) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         peak_ff  <= '0;
      end else begin
         count_ff <= count_in;
         peak_ff  <= peak_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_offset_ff <= ((status_ff == ST_OK) && !is_free_ff)
                          ? OFF_W'({alloc_start_ff, {BLK_SHIFT{1'b0}}}) : '0;
         rsp_free_ff   <= FREE_W'(CNT_W'(NUM_BLOCKS) - count_ff);
         rsp_lowest_ff <= FREE_W'(CNT_W'(NUM_BLOCKS) - peak_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_offset      = rsp_offset_ff;
   assign rsp_free_blocks = rsp_free_ff;
   assign rsp_lowest_free = rsp_lowest_ff;

   always_comb begin
      flags            = '0;
      flags.is_free    = is_free_ff;
      flags.zero_len   = (need_ff == '0);
      flags.too_big    = (need_ff > NEED_W'(NUM_BLOCKS));
      flags.addr_bad   = addr_bad_ff;
      flags.mark_used  = mark[1];
      flags.chain_more = mark[0] && (ptr_ff != LAST_IDX);
      flags.hit        = hit;
      flags.at_last    = (ptr_ff == LAST_IDX);
      flags.wr_last    = (run_len_ff == CNT_W'(1));
      flags.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

endmodule

`default_nettype wire

// File: hdl/first_fit_block_allocator_core.sv
// First-fit allocator over a heap of 64 blocks of 32 bytes, one request at a time. An allocate
// request rounds its length up to whole blocks and walks the mark memory from block 0, one
// entry per cycle, until the first free run of that size is found, then writes the run's
// marks one block per cycle; it answers no space when the walk reaches the last block with
// no run found. A free request walks the chain of marks from the given block, one block
// per cycle, and is ignored when the block is not in use. Zero length, oversized,
// out-of-range or misaligned requests go from decode straight to the response. The mark
// memory does one read and one write per cycle. A new request is taken as soon as the
// previous one is done, even while its response still waits in the output register.
// Marks read as free after reset with no clearing pass.
`default_nettype none

module first_fit_block_allocator_core (
   input  logic         clock,
   input  logic         reset,
   ffba_req_if.sink     req_channel,
   ffba_rsp_if.source   rsp_channel
);
   import ffba_pkg::*;

   cmd_type   cmd;
   flags_type flags;

   ffba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_channel.valid),
      .req_ready (req_channel.ready),
      .flags     (flags),
      .cmd       (cmd)
   );

   ffba_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_type        (req_channel.req_type),
      .req_length      (req_channel.length),
      .req_address     (req_channel.address),
      .cmd             (cmd),
      .flags           (flags),
      .rsp_ready       (rsp_channel.ready),
      .rsp_valid       (rsp_channel.valid),
      .rsp_status      (rsp_channel.status),
      .rsp_offset      (rsp_channel.offset),
      .rsp_free_blocks (rsp_channel.free_blocks),
      .rsp_lowest_free (rsp_channel.lowest_free)
   );

endmodule

`default_nettype wire

// File: hdl/ffba_chk.sv
`default_nettype none

module ffba_chk (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [1:0]                    rsp_status,
   input  logic [ffba_pkg::OFF_W-1:0]    rsp_offset,
   input  logic [ffba_pkg::FREE_W-1:0]   rsp_free_blocks,
   input  logic [ffba_pkg::FREE_W-1:0]   rsp_lowest_free
);
   import ffba_pkg::*;

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_offset)
         && $stable(rsp_free_blocks) && $stable(rsp_lowest_free))
      else $error("response changed while stalled");

   // low-water mark never above current free count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_lowest_free <= rsp_free_blocks)
         && (rsp_free_blocks <= FREE_W'(NUM_BLOCKS)))
      else $error("free counts inconsistent");

   // failed requests return offset zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != 2'(ST_OK)) |-> (rsp_offset == '0))
      else $error("offset set on failed request");

   // offsets are block aligned
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_offset[BLK_SHIFT-1:0] == '0))
      else $error("offset not block aligned");

endmodule

bind first_fit_block_allocator_core ffba_chk u_ffba_chk (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_channel.valid),
   .rsp_ready       (rsp_channel.ready),
   .rsp_status      (rsp_channel.status),
   .rsp_offset      (rsp_channel.offset),
   .rsp_free_blocks (rsp_channel.free_blocks),
   .rsp_lowest_free (rsp_channel.lowest_free)
);

`default_nettype wire

// File: verif/heap_result_checker.sv
`timescale 1ns / 100ps

module heap_result_checker (
   input  logic clock,
   input  logic reset,
   ffba_req_if  req_mon,
   ffba_rsp_if  rsp_mon,
   output int   failures,
   output int   pending,
   output int   grants,
   output int   releases,
   output int   refusals
);
   import ffba_pkg::*;

   typedef struct packed {
      status_type        status;
      logic [OFF_W-1:0]  offset;
      logic [FREE_W-1:0] free_blocks;
      logic [FREE_W-1:0] lowest_free;
   } heap_result_type;

   mark_type          heap_marks [NUM_BLOCKS];
   logic [CNT_W-1:0]  blocks_taken;
   logic [CNT_W-1:0]  peak_taken;
   heap_result_type   awaited_results [$];
   int                error_total   = 0;
   int                grant_total   = 0;
   int                release_total = 0;
   int                refusal_total = 0;

   function automatic void clear_heap_block(input int idx);
      if ((heap_marks[idx] & MARK_USED) != 0 && blocks_taken != 0) begin
         blocks_taken = blocks_taken - 1'b1;
      end
      heap_marks[idx] = MARK_FREE;
   endfunction

   function automatic heap_result_type serve_request(input req_kind_type kind,
                                                     input logic [LEN_W-1:0] len,
                                                     input logic [ADDR_W-1:0] addr);
      heap_result_type res;
      int              need;
      int              start;
      int              idx;
      bit              fits;
      res.status = ST_OK;
      res.offset = '0;
      if (kind == REQ_ALLOC) begin
         need = (int'(len) + BLOCK_BYTES - 1) / BLOCK_BYTES;
         if (len == 0) begin
            res.status = ST_ZERO_LEN;
         end else begin
            // first fit: lowest run of free blocks that is long enough
            res.status = ST_NO_SPACE;
            for (start = 0; start + need <= NUM_BLOCKS && res.status == ST_NO_SPACE;
                 start++) begin
               fits = 1'b1;
               for (idx = start; idx < start + need; idx++) begin
                  if (heap_marks[idx] != MARK_FREE) fits = 1'b0;
               end
               if (fits) begin
                  for (idx = start; idx < start + need - 1; idx++) begin
                     heap_marks[idx] = MARK_USED | MARK_NEXT;
                  end
                  heap_marks[start + need - 1] = MARK_USED;
                  blocks_taken = CNT_W'(int'(blocks_taken) + need);
                  if (blocks_taken > peak_taken) peak_taken = blocks_taken;
                  res.status = ST_OK;
                  res.offset = OFF_W'(start * BLOCK_BYTES);
               end
            end
         end
      end else if (addr >= HEAP_BYTES || addr % BLOCK_BYTES != 0) begin
         res.status = ST_IGNORED;
      end else begin
         idx = addr / BLOCK_BYTES;
         if ((heap_marks[idx] & MARK_USED) == 0) begin
            res.status = ST_IGNORED;
         end else begin
            // walk the chain, never past the last block
            while ((heap_marks[idx] & MARK_NEXT) != 0 && idx + 1 < NUM_BLOCKS) begin
               clear_heap_block(idx);
               idx++;
            end
            clear_heap_block(idx);
         end
      end
      res.free_blocks = FREE_W'(NUM_BLOCKS - int'(blocks_taken));
      res.lowest_free = FREE_W'(NUM_BLOCKS - int'(peak_taken));
      return res;
   endfunction

   always @(posedge clock) begin
      heap_result_type want;
      req_kind_type    kind;
      if (reset) begin
         foreach (heap_marks[i]) heap_marks[i] = MARK_FREE;
         blocks_taken = '0;
         peak_taken   = '0;
         awaited_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_results.size() == 0) begin
               $error("response with no request outstanding");
               error_total++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_mon.status != want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_mon.status);
                  error_total++;
               end
               if (rsp_mon.offset != want.offset) begin
                  $error("offset: expected %0d, actual %0d", want.offset, rsp_mon.offset);
                  error_total++;
               end
               if (rsp_mon.free_blocks != want.free_blocks) begin
                  $error("free_blocks: expected %0d, actual %0d", want.free_blocks,
                         rsp_mon.free_blocks);
                  error_total++;
               end
               if (rsp_mon.lowest_free != want.lowest_free) begin
                  $error("lowest_free: expected %0d, actual %0d", want.lowest_free,
                         rsp_mon.lowest_free);
                  error_total++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            kind = req_kind_type'(req_mon.req_type);
            want = serve_request(kind, req_mon.length, req_mon.address);
            awaited_results.push_back(want);
            if (want.status != ST_OK) refusal_total++;
            else if (kind == REQ_ALLOC) grant_total++;
            else release_total++;
         end
      end
      failures <= error_total;
      pending  <= awaited_results.size();
      grants   <= grant_total;
      releases <= release_total;
      refusals <= refusal_total;
   end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
   import ffba_pkg::*;

   localparam int RANDOM_REQUESTS = 1050;
   localparam int LONG_HOLD       = 400;
   localparam int DRAIN_CYCLES    = 150;

   logic clock = 1'b0;
   logic reset;
   int   send_idle_pct = 0;
   int   stall_pct     = 0;
   logic long_hold_req;
   int   sent_count    = 0;
   int   directed_count;
   int   failures;
   int   pending;
   int   grants;
   int   releases;
   int   refusals;

   ffba_req_if req_ch ();
   ffba_rsp_if rsp_ch ();

   first_fit_block_allocator_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_ch),
      .rsp_channel (rsp_ch)
   );

   heap_result_checker result_check (
      .clock    (clock),
      .reset    (reset),
      .req_mon  (req_ch),
      .rsp_mon  (rsp_ch),
      .failures (failures),
      .pending  (pending),
      .grants   (grants),
      .releases (releases),
      .refusals (refusals)
   );

   always #5 clock = ~clock;

   initial begin
      #10_000_000;
      $display("timeout with %0d responses outstanding", pending);
      $display("Mismatches found");
      $finish;
   end

   // response side: random stalls, plus one long hold-off
   initial begin
      int  held;
      bit  hold_done;
      held      = 0;
      hold_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req && !hold_done) begin
            rsp_ch.ready <= 1'b0;
            held++;
            if (held == LONG_HOLD) hold_done = 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic send_request(input req_kind_type kind, input logic [LEN_W-1:0] len,
                               input logic [ADDR_W-1:0] addr);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= kind;
      req_ch.length   <= len;
      req_ch.address  <= addr;
      do @(posedge clock); while (!req_ch.ready);
      sent_count++;
   endtask

   task automatic send_random_request();
      int                pick;
      int                size_pick;
      logic [LEN_W-1:0]  len;
      logic [ADDR_W-1:0] addr;
      pick = $urandom_range(99);
      len  = LEN_W'($urandom);
      addr = ADDR_W'($urandom);
      if (pick < 55) begin
         size_pick = $urandom_range(99);
         if (size_pick < 80) len = LEN_W'($urandom_range(256, 1));
         else if (size_pick < 95) len = LEN_W'($urandom_range(HEAP_BYTES, 1));
         send_request(REQ_ALLOC, len, addr);
      end else if (pick < 90) begin
         send_request(REQ_FREE, len,
                      ADDR_W'($urandom_range(NUM_BLOCKS - 1) * BLOCK_BYTES));
      end else begin
         case ($urandom_range(2))
            0: send_request(REQ_ALLOC, '0, addr);
            1: send_request(REQ_FREE, len, addr);
            default: send_request(REQ_ALLOC, len, addr);
         endcase
      end
   endtask

   initial begin
      int phase;
      reset           <= 1'b1;
      long_hold_req   <= 1'b0;
      req_ch.valid    <= 1'b0;
      req_ch.req_type <= REQ_ALLOC;
      req_ch.length   <= '0;
      req_ch.address  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(REQ_ALLOC, 16'd0, 16'hFFFF);
      send_request(REQ_FREE, 16'hFFFF, 16'd0);
      send_request(REQ_ALLOC, 16'd1, 16'd0);
      send_request(REQ_ALLOC, 16'd32, 16'd0);
      send_request(REQ_ALLOC, 16'd33, 16'd0);
      send_request(REQ_ALLOC, 16'hFFFF, 16'd0);
      send_request(REQ_FREE, 16'd0, 16'hFFFF);
      send_request(REQ_FREE, 16'd0, 16'(HEAP_BYTES));
      send_request(REQ_FREE, 16'd0, 16'd33);
      // free at the tail of a run, then from its head
      send_request(REQ_FREE, 16'd0, 16'd96);
      send_request(REQ_FREE, 16'd0, 16'd64);
      send_request(REQ_FREE, 16'd0, 16'd64);
      send_request(REQ_FREE, 16'd0, 16'd0);
      send_request(REQ_FREE, 16'd0, 16'd32);
      send_request(REQ_ALLOC, 16'(HEAP_BYTES), 16'd0);
      send_request(REQ_ALLOC, 16'd1, 16'd0);
      send_request(REQ_FREE, 16'd0, 16'(HEAP_BYTES - BLOCK_BYTES));
      send_request(REQ_FREE, 16'd0, 16'd0);
      send_request(REQ_ALLOC, 16'(HEAP_BYTES - BLOCK_BYTES + 1), 16'd0);
      send_request(REQ_FREE, 16'd0, 16'd0);
      send_request(REQ_ALLOC, 16'(HEAP_BYTES + 1), 16'd0);
      send_request(REQ_ALLOC, 16'd96, 16'd0);
      send_request(REQ_FREE, 16'd0, 16'(HEAP_BYTES - 1));
      directed_count = sent_count;

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
               long_hold_req <= 1'b1;
            end
            1: begin
               send_idle_pct = 73;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 73;
            end
            default: begin
               send_idle_pct = 32;
               stall_pct     = 32;
            end
         endcase
         repeat (RANDOM_REQUESTS / 4) send_random_request();
      end

      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d requests (%0d directed), random part under four idle and stall mixes",
               sent_count, directed_count);
      $display("%0d allocations granted, %0d frees applied, %0d refused or ignored",
               grants, releases, refusals);
      if (failures == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
